>>> design/range_sum_segment_tree_defines.svh
// ----------------------------------------------------------------------------
// range_sum_segment_tree_defines
// assertion macros used by the segment tree design file
// ----------------------------------------------------------------------------
`ifndef RANGE_SUM_SEGMENT_TREE_DEFINES_SVH
`define RANGE_SUM_SEGMENT_TREE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RSST_ASSERT_COMB(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define RSST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rsst_pkg.sv
// ----------------------------------------------------------------------------
// rsst_pkg
// field widths, reset element count, operation codes and controller states of the segment tree
// ----------------------------------------------------------------------------
package rsst_pkg;

    localparam int POS_W = 10;
    localparam int VAL_W = 32;
    localparam int CNT_W = 11;

    localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_QUERY
    } rsst_state_t;

endpackage

>>> design/rsst_if.sv
// ----------------------------------------------------------------------------
// rsst_if
// valid/ready channels for request items and sum results
// ----------------------------------------------------------------------------
interface rsst_item_if;
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic        [rsst_pkg::POS_W-1:0]   position;
    logic signed [rsst_pkg::VAL_W-1:0]   new_value;
    logic        [rsst_pkg::POS_W-1:0]   range_left;
    logic        [rsst_pkg::POS_W-1:0]   range_right;

    modport source (
        output valid, operation, position, new_value, range_left, range_right,
        input  ready
    );
    modport sink (
        input  valid, operation, position, new_value, range_left, range_right,
        output ready
    );
endinterface

interface rsst_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [rsst_pkg::VAL_W-1:0]   range_sum;

    modport source (
        output valid, range_sum,
        input  ready
    );
    modport sink (
        input  valid, range_sum,
        output ready
    );
endinterface

>>> design/range_sum_segment_tree.sv
// ----------------------------------------------------------------------------
// range_sum_segment_tree: point update, inclusive range sum over a node memory
// update: writes the leaf, then each parent on the path up to the root
// query: walks the bounds up the tree, then drains the read pipe; waits on held result
// reset: a clearing pass writes zero to every node, no transaction
// ----------------------------------------------------------------------------
`include "range_sum_segment_tree_defines.svh"

module range_sum_segment_tree #(
    parameter int ELEMENTS   = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [rsst_pkg::CNT_W-1:0]  cfg_wdata,
    rsst_item_if.sink                   item,
    rsst_result_if.source               result
);

    localparam int DEPTH = 2 * ELEMENTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);
    localparam int WW    = (NW > rsst_pkg::CNT_W) ? NW : rsst_pkg::CNT_W;
    localparam int XW    = (DATA_WIDTH > rsst_pkg::VAL_W) ? DATA_WIDTH : rsst_pkg::VAL_W;

    localparam logic [WW-1:0] ELEM_W    = WW'(ELEMENTS);
    localparam logic [AW-1:0] ROOT      = AW'(1);
    localparam logic [AW-1:0] LAST_NODE = AW'(DEPTH - 1);

    // node memory
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]         rd0_addr;
    logic [AW-1:0]         rd1_addr;
    logic [DATA_WIDTH-1:0] rd0_reg;
    logic [DATA_WIDTH-1:0] rd1_reg;

    // control
    rsst_pkg::rsst_state_t       state_reg, state_next;
    logic [rsst_pkg::CNT_W-1:0]  element_count_reg;
    logic [AW-1:0]               clr_addr_reg, clr_addr_next;
    logic                        f0_reg, f0_next;
    logic                        f1_reg, f1_next;
    logic                        out_valid_reg, out_valid_next;

    // datapath
    logic [AW-1:0]               node_reg, node_next;
    logic [DATA_WIDTH-1:0]       cur_reg, cur_next;
    logic [NW-1:0]               a_reg, a_next;
    logic [NW-1:0]               b_reg, b_next;
    logic [DATA_WIDTH-1:0]       pair_reg, pair_next;
    logic [DATA_WIDTH-1:0]       acc_reg, acc_next;
    logic [rsst_pkg::VAL_W-1:0]  out_sum_reg, out_sum_next;

    logic                        item_acc;
    logic [WW-1:0]               count_raw;
    logic [WW-1:0]               count_eff;
    logic [WW-1:0]               pos_w;
    logic [WW-1:0]               lo_w;
    logic [WW-1:0]               hi_w;
    logic [WW-1:0]               hi_clip;
    logic                        q_nonempty;
    logic [AW-1:0]               leaf;
    logic signed [XW-1:0]        new_ext;
    logic [DATA_WIDTH-1:0]       new_data;
    logic [AW-1:0]               parent;
    logic [DATA_WIDTH-1:0]       upd_sum;
    logic [NW-1:0]               a_step;
    logic [NW-1:0]               b_step;
    logic [NW-1:0]               b_dec;
    logic                        walk;
    logic                        q_done;
    logic                        out_free;
    logic [DATA_WIDTH-1:0]       final_sum;
    logic [XW-1:0]               sum_ext;

    assign item.ready   = (state_reg == rsst_pkg::ST_IDLE);
    assign item_acc     = item.valid && item.ready;
    assign result.valid = out_valid_reg;
    assign result.range_sum = out_sum_reg;

    assign count_raw  = WW'(element_count_reg);
    assign count_eff  = (count_raw > ELEM_W) ? ELEM_W : count_raw;
    assign pos_w      = WW'(item.position);
    assign lo_w       = WW'(item.range_left);
    assign hi_w       = WW'(item.range_right);
    assign hi_clip    = (hi_w >= count_eff) ? (count_eff - WW'(1)) : hi_w;
    assign q_nonempty = (count_eff != '0) && (lo_w <= hi_clip);
    assign leaf       = AW'(pos_w + ELEM_W);
    assign new_ext    = XW'(item.new_value);
    assign new_data   = new_ext[DATA_WIDTH-1:0];

    assign parent  = node_reg >> 1;
    assign upd_sum = cur_reg + rd0_reg;

    assign a_step = (a_reg + NW'(a_reg[0])) >> 1;
    assign b_step = b_reg >> 1;
    assign b_dec  = b_reg - NW'(1);
    assign walk   = (a_reg < b_reg);
    assign q_done = !walk && !f0_reg && !f1_reg;

    assign out_free  = !out_valid_reg || result.ready;
    assign final_sum = acc_reg + pair_reg;
    assign sum_ext   = XW'(final_sum);

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        node_next      = node_reg;
        cur_next       = cur_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        f0_next        = 1'b0;
        f1_next        = 1'b0;
        pair_next      = (f0_reg ? rd0_reg : '0) + (f1_reg ? rd1_reg : '0);
        acc_next       = acc_reg + pair_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_sum_next   = out_sum_reg;
        mem_we         = 1'b0;
        mem_waddr      = clr_addr_reg;
        mem_wdata      = '0;
        rd0_addr       = a_reg[AW-1:0];
        rd1_addr       = b_dec[AW-1:0];

        case (state_reg)
            rsst_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_addr_reg == LAST_NODE)
                begin
                    state_next = rsst_pkg::ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end
            rsst_pkg::ST_IDLE:
            begin
                if (item_acc)
                begin
                    if (item.operation == rsst_pkg::OP_UPDATE)
                    begin
                        if (pos_w < count_eff)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = leaf;
                            mem_wdata  = new_data;
                            rd0_addr   = leaf ^ AW'(1);
                            node_next  = leaf;
                            cur_next   = new_data;
                            state_next = rsst_pkg::ST_UPDATE;
                        end
                    end
                    else
                    begin
                        acc_next  = '0;
                        pair_next = '0;
                        if (q_nonempty)
                        begin
                            a_next = NW'(lo_w + ELEM_W);
                            b_next = NW'(hi_clip + ELEM_W + WW'(1));
                        end
                        else
                        begin
                            a_next = '0;
                            b_next = '0;
                        end
                        state_next = rsst_pkg::ST_QUERY;
                    end
                end
            end
            rsst_pkg::ST_UPDATE:
            begin
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = upd_sum;
                cur_next  = upd_sum;
                node_next = parent;
                rd0_addr  = parent ^ AW'(1);
                if (parent == ROOT)
                begin
                    state_next = rsst_pkg::ST_IDLE;
                end
            end
            rsst_pkg::ST_QUERY:
            begin
                if (walk)
                begin
                    f0_next = a_reg[0];
                    f1_next = b_reg[0];
                    a_next  = a_step;
                    b_next  = b_step;
                end
                else if (q_done && out_free)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = sum_ext[rsst_pkg::VAL_W-1:0];
                    state_next     = rsst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rsst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= rsst_pkg::ST_CLEAR;
            element_count_reg <= rsst_pkg::CNT_RESET;
            clr_addr_reg      <= '0;
            f0_reg            <= 1'b0;
            f1_reg            <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            f0_reg        <= f0_next;
            f1_reg        <= f1_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                element_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg    <= node_next;
        cur_reg     <= cur_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        pair_reg    <= pair_next;
        acc_reg     <= acc_next;
        out_sum_reg <= out_sum_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd0_reg <= mem[rd0_addr];
        rd1_reg <= mem[rd1_addr];
    end

    // update path never reads the node it writes in the same cycle
    `RSST_ASSERT_COMB(a_no_rw_overlap,
        mem_we && (state_reg != rsst_pkg::ST_CLEAR), mem_waddr != rd0_addr,
        "write and read of one node in the same cycle")
    `RSST_ASSERT_COMB(a_query_read_only, state_reg == rsst_pkg::ST_QUERY, !mem_we,
        "node memory written during a query")
    `RSST_ASSERT_COMB(a_walk_order, state_reg == rsst_pkg::ST_QUERY, a_reg <= b_reg,
        "query walk bounds crossed")
    `RSST_ASSERT_NEXT(a_update_climbs,
        (state_reg == rsst_pkg::ST_UPDATE) && (parent != ROOT),
        (state_reg == rsst_pkg::ST_UPDATE) && (node_reg == ($past(node_reg) >> 1)),
        "update did not move to the parent node")

endmodule
